@@ rtl/text_screen_cursor_buffer_core_defines.svh @@
// Assertion macros shared by the text screen cursor buffer RTL.
`ifndef TEXT_SCREEN_CURSOR_BUFFER_CORE_DEFINES_SVH
`define TEXT_SCREEN_CURSOR_BUFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TSCB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tscb assertion failed");
`define TSCB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tscb assertion failed");
`else
`define TSCB_ASSERT(label, clk, rst_n, prop)
`define TSCB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/tscb_pkg.sv @@
// Types and constants of the text screen cursor buffer.
package tscb_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int MAX_COLS   = 128;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int OP_W       = 4;
  localparam int STAT_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [ROW_W-1:0]  MAX_ROWS_V = ROW_W'(MAX_ROWS);
  localparam logic [COL_W-1:0]  MAX_COLS_V = COL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0]  HEIGHT_RST = ROW_W'(24);
  localparam logic [COL_W-1:0]  WIDTH_RST  = COL_W'(80);
  localparam logic [SIZE_W-1:0] SIZE_RST   = SIZE_W'(24 * 80);
  localparam logic [SIZE_W-1:0] LROW_RST   = SIZE_W'(23 * 80);

  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [OP_W-1:0] OP_FWD     = 4'd0;
  localparam logic [OP_W-1:0] OP_BACK    = 4'd1;
  localparam logic [OP_W-1:0] OP_UP      = 4'd2;
  localparam logic [OP_W-1:0] OP_DOWN    = 4'd3;
  localparam logic [OP_W-1:0] OP_HOME    = 4'd4;
  localparam logic [OP_W-1:0] OP_END     = 4'd5;
  localparam logic [OP_W-1:0] OP_MOVE    = 4'd6;
  localparam logic [OP_W-1:0] OP_READ_AT = 4'd7;
  localparam logic [OP_W-1:0] OP_WRITE   = 4'd8;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NULL  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;
    logic [CHAR_W-1:0] char_value;
  } tscb_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CHAR_W-1:0] char_at_cursor;
    logic [STAT_W-1:0] status;
  } tscb_out_t;

endpackage

@@ rtl/text_screen_cursor_buffer_core.sv @@
// Top level of the text screen cursor buffer: cursor control, cell RAM and result register.
//
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_stall   | tscb_in_t
// out     | output    | out_valid / out_stall | tscb_out_t
// cfg     | input     | cfg_valid / cfg_ready | cfg_addr, cfg_data
//
// A word goes through four steps: accept, execute, RAM read, capture into the result register.
// Clear adds a sweep over all 4096 cells of the cell RAM, one cell per cycle.
// After reset a pass over all 4096 cells fills the cell RAM with spaces; in_stall is high meanwhile.
// A new word is accepted while a result waits; its own result waits in the capture step.
// The configuration port is always ready.
`include "text_screen_cursor_buffer_core_defines.svh"

module text_screen_cursor_buffer_core
  import tscb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tscb_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tscb_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_CLEAR = 6'b001000,
    S_READ  = 6'b010000,
    S_WAIT  = 6'b100000
  } tscb_state_t;

  tscb_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CHAR_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  h_r, h_nxt;
  logic [COL_W-1:0]  w_r, w_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] lrow_r, lrow_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  tscb_in_t          in_r;
  tscb_out_t         out_data_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CHAR_W-1:0] mem_rdata;
  logic              out_load;

  logic [ROW_W+COL_W-1:0] size_prod;
  logic [ROW_W+COL_W-1:0] lrow_prod;
  logic [ROW_W-1:0]       h_m1;

  logic [SIZE_W-1:0]      cur_x, w_x, size_m1;
  logic [SIZE_W-1:0]      fwd_inc, up_wrap, up_step, dn_wrap, dn_step;
  logic [ROW_W-1:0]       row_m1;
  logic [COL_W-1:0]       col_m1;
  logic [ROW_W+COL_W-1:0] place_prod, place_sum;
  logic                   coords_ok;
  logic [ADDR_W-1:0]      exec_cursor;
  logic [STAT_W-1:0]      exec_stat;
  logic [ROW_W-1:0]       cfg_h;
  logic [COL_W-1:0]       cfg_w;

  tscb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(cursor_r),
    .rd_data(mem_rdata)
  );

  assign h_m1      = h_r - 1'b1;
  assign size_prod = h_r * w_r;
  assign lrow_prod = h_m1 * w_r;
  assign size_nxt  = size_prod[SIZE_W-1:0];
  assign lrow_nxt  = lrow_prod[SIZE_W-1:0];

  assign cur_x   = {1'b0, cursor_r};
  assign w_x     = {{(SIZE_W-COL_W){1'b0}}, w_r};
  assign size_m1 = size_r - 1'b1;
  assign fwd_inc = cur_x + 1'b1;
  assign up_wrap = cur_x + lrow_r - 1'b1;
  assign up_step = cur_x - w_x;
  assign dn_wrap = cur_x - lrow_r;
  assign dn_step = cur_x + w_x;

  assign row_m1     = in_r.target_row - 1'b1;
  assign col_m1     = in_r.target_col - 1'b1;
  assign place_prod = row_m1 * w_r;
  assign place_sum  = place_prod + {{ROW_W{1'b0}}, col_m1};
  assign coords_ok  = (in_r.target_row != '0) && (in_r.target_row <= h_r) &&
                      (in_r.target_col != '0) && (in_r.target_col <= w_r);

  always_comb begin
    exec_cursor = cursor_r;
    exec_stat   = ST_OK;
    case (in_r.operation)
      OP_FWD: begin
        exec_cursor = (fwd_inc >= size_r) ? '0 : fwd_inc[ADDR_W-1:0];
      end
      OP_BACK: begin
        exec_cursor = (cursor_r == '0) ? size_m1[ADDR_W-1:0] : cursor_r - 1'b1;
      end
      OP_UP: begin
        if (cursor_r == '0) begin
          exec_cursor = size_m1[ADDR_W-1:0];
        end else if (cur_x < w_x) begin
          exec_cursor = up_wrap[ADDR_W-1:0];
        end else begin
          exec_cursor = up_step[ADDR_W-1:0];
        end
      end
      OP_DOWN: begin
        if (cur_x == size_m1) begin
          exec_cursor = '0;
        end else if (cur_x >= lrow_r) begin
          exec_cursor = dn_wrap[ADDR_W-1:0];
        end else begin
          exec_cursor = dn_step[ADDR_W-1:0];
        end
      end
      OP_HOME: begin
        exec_cursor = '0;
      end
      OP_END: begin
        exec_cursor = size_m1[ADDR_W-1:0];
      end
      OP_MOVE, OP_READ_AT: begin
        if (coords_ok) begin
          exec_cursor = place_sum[ADDR_W-1:0];
        end else begin
          exec_stat = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (in_r.char_value == NUL_CHAR) begin
          exec_stat = ST_NULL;
        end
      end
      OP_CLEAR: begin
        exec_cursor = '0;
      end
      default: begin
        exec_cursor = cursor_r;
      end
    endcase
  end

  always_comb begin
    if (cfg_data[ROW_W-1:0] == '0) begin
      cfg_h = ROW_W'(1);
    end else if (cfg_data[ROW_W-1:0] > MAX_ROWS_V) begin
      cfg_h = MAX_ROWS_V;
    end else begin
      cfg_h = cfg_data[ROW_W-1:0];
    end
    if (cfg_data[COL_W-1:0] == '0) begin
      cfg_w = COL_W'(1);
    end else if (cfg_data[COL_W-1:0] > MAX_COLS_V) begin
      cfg_w = MAX_COLS_V;
    end else begin
      cfg_w = cfg_data[COL_W-1:0];
    end
  end

  assign out_load = (state_r == S_WAIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    cursor_nxt    = cursor_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = fill_r;
    mem_re        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cursor_nxt = exec_cursor;
        stat_nxt   = exec_stat;
        if (in_r.operation == OP_WRITE && in_r.char_value != NUL_CHAR) begin
          mem_we    = 1'b1;
          mem_waddr = cursor_r;
          mem_wdata = in_r.char_value;
        end
        if (in_r.operation == OP_CLEAR) begin
          fill_nxt  = in_r.char_value;
          cnt_nxt   = '0;
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      if (cfg_addr == CFG_HEIGHT) begin
        h_nxt      = cfg_h;
        cursor_nxt = '0;
      end else if (cfg_addr == CFG_WIDTH) begin
        w_nxt      = cfg_w;
        cursor_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      fill_r      <= BLANK_CHAR;
      cursor_r    <= '0;
      h_r         <= HEIGHT_RST;
      w_r         <= WIDTH_RST;
      size_r      <= SIZE_RST;
      lrow_r      <= LROW_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      cursor_r    <= cursor_nxt;
      h_r         <= h_nxt;
      w_r         <= w_nxt;
      size_r      <= size_nxt;
      lrow_r      <= lrow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (out_load) begin
      out_data_r.cursor_pos     <= cursor_r;
      out_data_r.char_at_cursor <= mem_rdata;
      out_data_r.status         <= stat_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `TSCB_ASSERT(a_cursor_in_screen, clk, rst_n, (state_r == S_IDLE) |-> (cur_x < size_r))
  `TSCB_ASSERT(a_no_write_idle, clk, rst_n, (state_r == S_IDLE) |-> !mem_we)
  `TSCB_ASSERT(a_result_from_wait, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_WAIT))
  `TSCB_ASSERT(a_clear_then_read, clk, rst_n, (state_r == S_CLEAR && cnt_r == '1) |=> (state_r == S_READ))

endmodule

@@ rtl/tscb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tscb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
